// File: design/kmst_pkg.sv
// kruskal spanning tree weight unit: shared types and constants
// no dependencies
package kmst_pkg;

	localparam int MAX_NODES = 128;
	localparam int MAX_EDGES = 1024;
	localparam int NODE_W = 7;
	localparam int EADDR_W = 10;
	localparam int FILL_W = 11;
	localparam int WGT_W = 16;
	localparam int SUM_W = 23;
	localparam int EDGE_W = 2 * NODE_W + WGT_W;

	typedef enum logic [1:0] {
		ACT_APPEND = 2'd0,
		ACT_RUN    = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SORT_OUTER,
		ST_SORT_RDKEY,
		ST_SORT_KEY,
		ST_SORT_RDPREV,
		ST_SORT_CMP,
		ST_PINIT,
		ST_WALK_RD,
		ST_WALK_EDGE,
		ST_FIND_RD,
		ST_FIND_CHK,
		ST_COMP_RD,
		ST_COMP_WR,
		ST_JOIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		logic signed [WGT_W-1:0] w;
	} edge_t;

endpackage

// File: design/kruskal_mst_weight_unit.sv
// kruskal spanning tree weight unit: top level with sequencer
// depends on kmst_pkg and kmst_ram
//
// input channel (valid/ready): action with edge fields. append stores an
// edge, clear empties the store, run produces one result item.
// output channel (out_valid/out_ready) carries total weight, edge count,
// spanning and overflow flags, held in an output register.
// a run insertion-sorts the edge store in place (it fetches each key, reads
// and compares each earlier element and moves it up while it is heavier,
// placing the key at the front when no element is left), then sweeps all
// 128 entries of the parent table, then walks edges with an edge fetch,
// find steps, compression steps and a join per edge; all work goes through
// the single port of the edge ram or the parent ram.
// in_ready is low while a run is busy or while a result waits on a stalled
// receiver.
// reset clears fill count, overflow flag and node_count to 128; the parent
// table is rebuilt after the sort in every run, so no clearing pass is needed.
module kruskal_mst_weight_unit
	import kmst_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [7:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] action,
	input  logic [NODE_W-1:0] node_a,
	input  logic [NODE_W-1:0] node_b,
	input  logic signed [WGT_W-1:0] edge_weight,
	output logic out_valid,
	input  logic out_ready,
	output logic signed [SUM_W-1:0] total_weight,
	output logic [6:0] edges_taken,
	output logic spanning,
	output logic store_overflow
);
	state_t state_q, state_d;
	logic [7:0] node_count_q;
	logic [FILL_W-1:0] fill_q;
	logic ovf_q;
	logic [FILL_W-1:0] i_q, i_d, j_q, j_d;
	edge_t key_q, key_d, prev_q, prev_d;
	logic [NODE_W:0] pi_q, pi_d;
	logic [NODE_W-1:0] r_q, r_d, n_q, n_d, x_q, x_d;
	logic side_q, side_d;
	logic signed [SUM_W+1:0] sum_q, sum_d;
	logic [7:0] taken_q, taken_d;
	edge_t cur_q, cur_d;

	logic e_we, p_we;
	logic [EADDR_W-1:0] e_addr;
	edge_t e_wdata, e_rdata;
	logic [NODE_W-1:0] p_addr, p_wdata, p_rdata;

	kmst_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk(clk), .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata));
	kmst_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_parent_ram (
		.clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wdata), .rdata(p_rdata));

	logic stop_en;
	logic [7:0] target;
	assign stop_en = node_count_q != 8'd0;
	assign target = node_count_q - 8'd1;

	logic res_load;
	assign in_ready = (state_q == ST_IDLE) && !out_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			node_count_q <= 8'd128;
			fill_q <= '0;
			ovf_q <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				node_count_q <= cfg_wdata;
			if (in_valid && in_ready) begin
				if (action_t'(action) == ACT_APPEND) begin
					if (fill_q < FILL_W'(MAX_EDGES))
						fill_q <= fill_q + 1'b1;
					else
						ovf_q <= 1'b1;
				end else if (action_t'(action) == ACT_CLEAR) begin
					fill_q <= '0;
					ovf_q <= 1'b0;
				end
			end
			if (res_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		i_q <= i_d;
		j_q <= j_d;
		key_q <= key_d;
		prev_q <= prev_d;
		pi_q <= pi_d;
		r_q <= r_d;
		n_q <= n_d;
		x_q <= x_d;
		side_q <= side_d;
		sum_q <= sum_d;
		taken_q <= taken_d;
		cur_q <= cur_d;
		if (res_load) begin
			if (sum_q > (SUM_W+2)'(4194303))
				total_weight <= SUM_W'(4194303);
			else if (sum_q < -(SUM_W+2)'(4194304))
				total_weight <= SUM_W'(-4194304);
			else
				total_weight <= SUM_W'(sum_q);
			edges_taken <= (taken_q > 8'd127) ? 7'd127 : taken_q[6:0];
			spanning <= stop_en && (taken_q == target);
			store_overflow <= ovf_q;
		end
	end

	always_comb begin
		state_d = state_q;
		i_d = i_q; j_d = j_q; key_d = key_q; prev_d = prev_q; pi_d = pi_q;
		r_d = r_q; n_d = n_q; x_d = x_q; side_d = side_q;
		sum_d = sum_q; taken_d = taken_q; cur_d = cur_q;
		e_we = 1'b0; e_addr = fill_q[EADDR_W-1:0];
		e_wdata = '{a: node_a, b: node_b, w: edge_weight};
		p_we = 1'b0; p_addr = r_q; p_wdata = r_q;
		res_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					if (action_t'(action) == ACT_APPEND)
						e_we = fill_q < FILL_W'(MAX_EDGES);
					else if (action_t'(action) == ACT_RUN) begin
						i_d = FILL_W'(1);
						state_d = ST_SORT_OUTER;
					end
				end
			end
			ST_SORT_OUTER: begin
				if (i_q < fill_q) begin
					e_addr = i_q[EADDR_W-1:0];
					state_d = ST_SORT_RDKEY;
				end else begin
					pi_d = '0;
					state_d = ST_PINIT;
				end
			end
			ST_SORT_RDKEY: begin
				e_addr = i_q[EADDR_W-1:0];
				key_d = e_rdata;
				j_d = i_q;
				state_d = ST_SORT_KEY;
			end
			ST_SORT_KEY: begin
				if (j_q == '0) begin
					e_we = 1'b1; e_addr = '0; e_wdata = key_q;
					i_d = i_q + 1'b1;
					state_d = ST_SORT_OUTER;
				end else begin
					e_addr = EADDR_W'(j_q - 1'b1);
					state_d = ST_SORT_RDPREV;
				end
			end
			ST_SORT_RDPREV: begin
				e_addr = EADDR_W'(j_q - 1'b1);
				prev_d = e_rdata;
				state_d = ST_SORT_CMP;
			end
			ST_SORT_CMP: begin
				e_we = 1'b1;
				e_addr = j_q[EADDR_W-1:0];
				if (prev_q.w > key_q.w) begin
					e_wdata = prev_q;
					j_d = j_q - 1'b1;
					state_d = ST_SORT_KEY;
				end else begin
					e_wdata = key_q;
					i_d = i_q + 1'b1;
					state_d = ST_SORT_OUTER;
				end
			end
			ST_PINIT: begin
				p_we = 1'b1;
				p_addr = pi_q[NODE_W-1:0];
				p_wdata = pi_q[NODE_W-1:0];
				pi_d = pi_q + 1'b1;
				if (pi_q == (NODE_W+1)'(MAX_NODES - 1)) begin
					i_d = '0; sum_d = '0; taken_d = '0;
					state_d = ST_WALK_RD;
				end
			end
			ST_WALK_RD: begin
				e_addr = i_q[EADDR_W-1:0];
				if (i_q >= fill_q || (stop_en && taken_q == target))
					state_d = ST_DONE;
				else
					state_d = ST_WALK_EDGE;
			end
			ST_WALK_EDGE: begin
				e_addr = i_q[EADDR_W-1:0];
				cur_d = e_rdata;
				side_d = 1'b0;
				r_d = e_rdata.a;
				state_d = ST_FIND_RD;
			end
			ST_FIND_RD: begin
				p_addr = r_q;
				state_d = ST_FIND_CHK;
			end
			ST_FIND_CHK: begin
				p_addr = r_q;
				if (p_rdata == r_q) begin
					n_d = side_q ? cur_q.b : cur_q.a;
					state_d = ST_COMP_RD;
				end else begin
					r_d = p_rdata;
					state_d = ST_FIND_RD;
				end
			end
			ST_COMP_RD: begin
				p_addr = n_q;
				state_d = ST_COMP_WR;
			end
			ST_COMP_WR: begin
				p_addr = n_q;
				if (p_rdata != r_q) begin
					p_we = 1'b1;
					p_wdata = r_q;
					n_d = p_rdata;
					state_d = ST_COMP_RD;
				end else if (!side_q) begin
					x_d = r_q;
					side_d = 1'b1;
					r_d = cur_q.b;
					state_d = ST_FIND_RD;
				end else
					state_d = ST_JOIN;
			end
			ST_JOIN: begin
				if (x_q != r_q) begin
					p_we = 1'b1;
					p_addr = x_q;
					p_wdata = r_q;
					taken_d = taken_q + 1'b1;
					sum_d = sum_q + (SUM_W+2)'(cur_q.w);
				end
				i_d = i_q + 1'b1;
				state_d = ST_WALK_RD;
			end
			ST_DONE: begin
				res_load = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MAX_EDGES))
		else $error("fill count beyond store depth");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready)
		else $error("ready while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> !out_valid)
		else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK_RD |-> taken_q <= 8'd128)
		else $error("taken count too large");
endmodule

// File: design/kmst_ram.sv
// generic single-port synchronous ram, registered read
// no dependencies
module kmst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// File: tb/kruskal_mst_weight_unit_tb.sv
`timescale 1ns / 100ps
// testbench for kruskal_mst_weight_unit: directed and random edge sets,
// runs and clears checked against an in-bench spanning tree calculator
// depends on kmst_pkg and the design files
module kruskal_mst_weight_unit_tb;
	import kmst_pkg::*;

	typedef struct {
		logic signed [SUM_W-1:0] total;
		logic [6:0] taken;
		logic span;
		logic ovf;
	} mst_result_t;

	class mst_scoreboard;
		logic [NODE_W-1:0] end_a[MAX_EDGES];
		logic [NODE_W-1:0] end_b[MAX_EDGES];
		int wgt[MAX_EDGES];
		int fill;
		bit ovf_seen;
		int node_count;
		int fails;
		mst_result_t pending_totals[$];

		function new();
			fill = 0;
			ovf_seen = 0;
			node_count = 128;
			fails = 0;
		endfunction

		function void note_item(action_t act, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
				logic signed [WGT_W-1:0] w);
			int parent[MAX_NODES];
			int i, j, x, y, nxt, taken, target, ka, kb, kw;
			longint sum;
			bit stop_on;
			mst_result_t r;
			case (act)
				ACT_APPEND: begin
					if (fill < MAX_EDGES) begin
						end_a[fill] = a;
						end_b[fill] = b;
						wgt[fill] = int'(w);
						fill++;
					end else begin
						ovf_seen = 1;
					end
				end
				ACT_CLEAR: begin
					fill = 0;
					ovf_seen = 0;
				end
				ACT_RUN: begin
					for (i = 1; i < fill; i++) begin
						ka = int'(end_a[i]);
						kb = int'(end_b[i]);
						kw = wgt[i];
						j = i;
						while (j > 0 && wgt[j-1] > kw) begin
							end_a[j] = end_a[j-1];
							end_b[j] = end_b[j-1];
							wgt[j] = wgt[j-1];
							j--;
						end
						end_a[j] = NODE_W'(ka);
						end_b[j] = NODE_W'(kb);
						wgt[j] = kw;
					end
					for (i = 0; i < MAX_NODES; i++)
						parent[i] = i;
					stop_on = node_count >= 1;
					target = stop_on ? node_count - 1 : 0;
					taken = 0;
					sum = 0;
					for (i = 0; i < fill; i++) begin
						if (stop_on && taken == target)
							break;
						x = int'(end_a[i]);
						while (parent[x] != x)
							x = parent[x];
						j = int'(end_a[i]);
						while (parent[j] != x) begin
							nxt = parent[j];
							parent[j] = x;
							j = nxt;
						end
						y = int'(end_b[i]);
						while (parent[y] != y)
							y = parent[y];
						j = int'(end_b[i]);
						while (parent[j] != y) begin
							nxt = parent[j];
							parent[j] = y;
							j = nxt;
						end
						if (x != y) begin
							parent[x] = y;
							taken++;
							sum += wgt[i];
						end
					end
					if (sum > 4194303)
						sum = 4194303;
					if (sum < -4194304)
						sum = -4194304;
					r.total = SUM_W'(sum);
					r.taken = 7'(taken > 127 ? 127 : taken);
					r.span = stop_on && taken == target;
					r.ovf = ovf_seen;
					pending_totals.insert(pending_totals.size(), r);
				end
				default: ;
			endcase
		endfunction

		function void check_result(mst_result_t got);
			mst_result_t exp_r;
			if (pending_totals.size() == 0) begin
				$error("result with no run pending");
				fails++;
				return;
			end
			exp_r = pending_totals.pop_front();
			if (got.total !== exp_r.total) begin
				$error("total_weight expected %0d got %0d", exp_r.total, got.total);
				fails++;
			end
			if (got.taken !== exp_r.taken) begin
				$error("edges_taken expected %0d got %0d", exp_r.taken, got.taken);
				fails++;
			end
			if (got.span !== exp_r.span) begin
				$error("spanning expected %0b got %0b", exp_r.span, got.span);
				fails++;
			end
			if (got.ovf !== exp_r.ovf) begin
				$error("store_overflow expected %0b got %0b", exp_r.ovf, got.ovf);
				fails++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;
	logic in_valid;
	logic in_ready;
	logic [1:0] action;
	logic [NODE_W-1:0] node_a;
	logic [NODE_W-1:0] node_b;
	logic signed [WGT_W-1:0] edge_weight;
	logic out_valid;
	logic out_ready;
	logic signed [SUM_W-1:0] total_weight;
	logic [6:0] edges_taken;
	logic spanning;
	logic store_overflow;

	mst_scoreboard sb;
	bit calm;
	int sent;

	kruskal_mst_weight_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.node_a(node_a),
		.node_b(node_b),
		.edge_weight(edge_weight),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.total_weight(total_weight),
		.edges_taken(edges_taken),
		.spanning(spanning),
		.store_overflow(store_overflow)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#1_000_000_000;
		$display("kruskal_mst_weight_unit_tb NOT OK");
		$finish;
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 0;
		else
			out_ready <= calm || $urandom_range(0, 99) >= 20;
	end

	always @(posedge clk) begin
		mst_result_t got;
		if (arst_n && out_valid && out_ready) begin
			got.total = total_weight;
			got.taken = edges_taken;
			got.span = spanning;
			got.ovf = store_overflow;
			sb.check_result(got);
		end
	end

	task send_item(action_t act, int a, int b, int w);
		if (!calm && $urandom_range(0, 99) < 20) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1;
		action <= act;
		node_a <= NODE_W'(a);
		node_b <= NODE_W'(b);
		edge_weight <= WGT_W'(w);
		do @(posedge clk); while (!in_ready);
		sb.note_item(act, NODE_W'(a), NODE_W'(b), WGT_W'(w));
		if (act != ACT_NONE)
			sent++;
	endtask

	task wait_idle();
		in_valid <= 0;
		while (sb.pending_totals.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task set_nodes(int v);
		cfg_we <= 1;
		cfg_wdata <= 8'(v);
		@(posedge clk);
		cfg_we <= 0;
		sb.node_count = v;
	endtask

	task add_random_edge(int span_n);
		send_item(ACT_APPEND, $urandom_range(0, span_n - 1), $urandom_range(0, span_n - 1),
			$urandom_range(0, 3) == 0 ? $urandom_range(0, 65535) : $urandom_range(0, 200) - 100);
	endtask

	initial begin
		int nc, span_n, rounds, k;
		int nc_list[5];
		sb = new();
		calm = 0;
		sent = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		in_valid = 0;
		action = ACT_NONE;
		node_a = 0;
		node_b = 0;
		edge_weight = 0;
		nc_list = '{1, 0, 2, 3, 255};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// empty store at reset width, ignored action, extreme edges
		send_item(ACT_RUN, 0, 0, 0);
		send_item(ACT_NONE, 127, 127, -1);
		send_item(ACT_APPEND, 0, 127, 32767);
		send_item(ACT_APPEND, 127, 0, -32768);
		send_item(ACT_APPEND, 5, 5, 0);
		send_item(ACT_APPEND, 0, 1, -1);
		send_item(ACT_APPEND, 1, 2, 100);
		send_item(ACT_APPEND, 2, 0, 100);
		send_item(ACT_RUN, 0, 0, 0);
		wait_idle();
		foreach (nc_list[i]) begin
			set_nodes(nc_list[i]);
			send_item(ACT_RUN, 0, 0, 0);
			wait_idle();
		end
		set_nodes(128);
		send_item(ACT_CLEAR, 0, 0, 0);
		send_item(ACT_RUN, 0, 0, 0);

		// fill the store in weight order so the sort stays short, then overflow it
		calm = 1;
		for (int i = 0; i < MAX_EDGES; i++)
			send_item(ACT_APPEND, $urandom_range(0, 127), $urandom_range(0, 127),
				i * 64 - 32768);
		send_item(ACT_RUN, 0, 0, 0);
		send_item(ACT_APPEND, 3, 4, 32767);
		send_item(ACT_RUN, 0, 0, 0);
		send_item(ACT_CLEAR, 0, 0, 0);
		send_item(ACT_RUN, 0, 0, 0);
		calm = 0;

		while (sent < 1900) begin
			wait_idle();
			calm = $urandom_range(0, 5) == 0;
			case ($urandom_range(0, 9))
				0: nc = 0;
				1: nc = 1;
				2: nc = 128;
				3: nc = 255;
				default: nc = $urandom_range(2, 24);
			endcase
			set_nodes(nc);
			span_n = (nc == 0 || nc > 128) ? 128 : nc;
			if ($urandom_range(0, 1) || sb.fill > 60)
				send_item(ACT_CLEAR, 0, 0, 0);
			rounds = $urandom_range(1, 3);
			for (int r = 0; r < rounds; r++) begin
				k = $urandom_range(1, 20);
				for (int e = 0; e < k; e++) begin
					if ($urandom_range(0, 19) == 0)
						send_item(ACT_NONE, $urandom_range(0, 127), $urandom_range(0, 127),
							$urandom_range(0, 65535));
					else if ($urandom_range(0, 9) == 0)
						add_random_edge(128);
					else
						add_random_edge(span_n);
				end
				if ($urandom_range(0, 15) == 0)
					send_item(ACT_CLEAR, 0, 0, 0);
				send_item(ACT_RUN, 0, 0, 0);
			end
		end
		wait_idle();
		repeat (50) @(posedge clk);
		if (sb.fails == 0 && sb.pending_totals.size() == 0)
			$display("kruskal_mst_weight_unit_tb OK");
		else
			$display("kruskal_mst_weight_unit_tb NOT OK");
		$finish;
	end

endmodule
